// File: src/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lvp_pkg.sv
// Types, constants and helper functions for the laminar voxel probe.
// No dependencies.
package lvp_pkg;

  localparam int unsigned LayerW    = 16;
  localparam int unsigned NumLayers = 4;
  localparam int unsigned MaxLayers = 4;
  localparam int unsigned LayerLimit = (MaxLayers < NumLayers) ? MaxLayers : NumLayers;
  localparam int unsigned CountW    = 3;
  localparam int unsigned SelW      = 2;
  localparam int unsigned ThreshW   = 17;
  localparam int unsigned SumW      = 18;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 17;

  typedef logic signed [LayerW-1:0] layer_t;
  typedef logic [LayerW:0]          mag_t;

  typedef enum logic [3:0] {
    ModeSelect   = 4'd0,
    ModeConjL0L1 = 4'd1,
    ModeConjN0L2 = 4'd2,
    ModeConjN1N2 = 4'd3,
    ModeConjN0N1 = 4'd4,
    ModeConjL0N2 = 4'd5,
    ModeConjL1L2 = 4'd6,
    ModeArgMax   = 4'd7,
    ModeArgMin   = 4'd8,
    ModeExtreme  = 4'd9
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMode       = 3'd0,
    RegSelLayer   = 3'd1,
    RegInvert     = 3'd2,
    RegLayerCount = 3'd3,
    RegThreshold  = 3'd4
  } reg_e;

  // Negate, clamping the most negative value to the most positive.
  function automatic layer_t sat_neg(layer_t x);
    layer_t r;
    if (x == {1'b1, {(LayerW-1){1'b0}}}) begin
      r = {1'b0, {(LayerW-1){1'b1}}};
    end else begin
      r = -x;
    end
    return r;
  endfunction

  // Operand nearer zero when both share a strict sign, else zero.
  function automatic layer_t conj(layer_t a, layer_t b);
    layer_t r;
    r = '0;
    if (a > 0 && b > 0) begin
      r = (b < a) ? b : a;
    end else if (a < 0 && b < 0) begin
      r = (b > a) ? b : a;
    end
    return r;
  endfunction

  function automatic mag_t abs_mag(layer_t x);
    logic signed [LayerW:0] e;
    mag_t r;
    e = {x[LayerW-1], x};
    r = e[LayerW] ? mag_t'(-e) : mag_t'(e);
    return r;
  endfunction

endpackage

// File: src/laminar_voxel_probe.sv
// Laminar voxel probe top level: config registers, input register, result register.
// Depends on lvp_pkg.
//
// Each voxel request (four signed Q7.8 layers) yields one Q7.8 result: the
// request lands in an input register, a compare-and-select over the four layers
// picked by the mode register feeds the result register, which holds it until
// the sink takes it. The input register refills when empty or when the result
// stage advances, so one request per clock is sustained while the sink keeps
// m_axis_tready high. Write configuration only while no request is in flight;
// writes to indexes above four are dropped.
module laminar_voxel_probe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // layer_0 [15:0], layer_1 [31:16], layer_2 [47:32], layer_3 [63:48]
  input  logic [4*lvp_pkg::LayerW-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // result_value [15:0]
  output logic [lvp_pkg::LayerW-1:0]   m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [lvp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lvp_pkg::CfgDataW-1:0] cfg_wdata_i
);

  lvp_pkg::mode_e                 mode_q;
  logic [lvp_pkg::SelW-1:0]       sel_layer_q;
  logic                           invert_q;
  logic [lvp_pkg::CountW-1:0]     layer_count_q;
  logic [lvp_pkg::ThreshW-1:0]    threshold_q;

  logic                           in_valid_q;
  lvp_pkg::layer_t                layers_q [lvp_pkg::NumLayers];
  logic                           out_valid_q;
  lvp_pkg::layer_t                result_q;
  lvp_pkg::layer_t                result_d;
  logic                           stage_ready;
  logic [lvp_pkg::CountW-1:0]     n_eff;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= lvp_pkg::ModeSelect;
      sel_layer_q   <= '0;
      invert_q      <= 1'b0;
      layer_count_q <= lvp_pkg::CountW'(3);
      threshold_q   <= lvp_pkg::ThreshW'(1);
    end else if (cfg_we_i) begin
      unique case (lvp_pkg::reg_e'(cfg_index_i))
        lvp_pkg::RegMode:       mode_q        <= lvp_pkg::mode_e'(cfg_wdata_i[3:0]);
        lvp_pkg::RegSelLayer:   sel_layer_q   <= cfg_wdata_i[lvp_pkg::SelW-1:0];
        lvp_pkg::RegInvert:     invert_q      <= cfg_wdata_i[0];
        lvp_pkg::RegLayerCount: layer_count_q <= cfg_wdata_i[lvp_pkg::CountW-1:0];
        lvp_pkg::RegThreshold:  threshold_q   <= cfg_wdata_i[lvp_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

  assign stage_ready   = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || stage_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (stage_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      for (int i = 0; i < lvp_pkg::NumLayers; i++) begin
        layers_q[i] <= s_axis_tdata[i*lvp_pkg::LayerW +: lvp_pkg::LayerW];
      end
    end
    if (in_valid_q && stage_ready) begin
      result_q <= result_d;
    end
  end

  // Clamp the layer count to the layers that exist.
  assign n_eff = (layer_count_q > lvp_pkg::CountW'(lvp_pkg::LayerLimit))
               ? lvp_pkg::CountW'(lvp_pkg::LayerLimit) : layer_count_q;

  always_comb begin
    logic [lvp_pkg::SumW-1:0]   sum;
    lvp_pkg::layer_t            best;
    logic [lvp_pkg::CountW-1:0] best_idx;
    lvp_pkg::layer_t            zpos;
    lvp_pkg::layer_t            zneg;
    lvp_pkg::layer_t            sel;
    logic                       take;

    sum      = '0;
    best     = '0;
    best_idx = '0;
    zpos     = '0;
    zneg     = '0;
    take     = 1'b0;
    for (int j = 0; j < lvp_pkg::NumLayers; j++) begin
      if (lvp_pkg::CountW'(j) < n_eff) begin
        sum = sum + lvp_pkg::SumW'(lvp_pkg::abs_mag(layers_q[j]));
        // Strict compare keeps the lowest-numbered layer on ties.
        if (j == 0) begin
          take = 1'b1;
        end else if (mode_q == lvp_pkg::ModeArgMax) begin
          take = layers_q[j] > best;
        end else begin
          take = layers_q[j] < best;
        end
        if (take) begin
          best     = layers_q[j];
          best_idx = lvp_pkg::CountW'(j + 1);
        end
        if (layers_q[j] > zpos) begin
          zpos = layers_q[j];
        end
        if (layers_q[j] < zneg) begin
          zneg = layers_q[j];
        end
      end
    end

    sel = layers_q[sel_layer_q];
    result_d = '0;
    unique case (mode_q)
      lvp_pkg::ModeSelect:   result_d = invert_q ? lvp_pkg::sat_neg(sel) : sel;
      lvp_pkg::ModeConjL0L1: result_d = lvp_pkg::conj(layers_q[0], layers_q[1]);
      lvp_pkg::ModeConjN0L2: result_d = lvp_pkg::conj(lvp_pkg::sat_neg(layers_q[0]),
                                                      layers_q[2]);
      lvp_pkg::ModeConjN1N2: result_d = lvp_pkg::conj(lvp_pkg::sat_neg(layers_q[1]),
                                                      lvp_pkg::sat_neg(layers_q[2]));
      lvp_pkg::ModeConjN0N1: result_d = lvp_pkg::conj(lvp_pkg::sat_neg(layers_q[0]),
                                                      lvp_pkg::sat_neg(layers_q[1]));
      lvp_pkg::ModeConjL0N2: result_d = lvp_pkg::conj(layers_q[0],
                                                      lvp_pkg::sat_neg(layers_q[2]));
      lvp_pkg::ModeConjL1L2: result_d = lvp_pkg::conj(layers_q[1], layers_q[2]);
      lvp_pkg::ModeArgMax, lvp_pkg::ModeArgMin: begin
        if (best_idx != '0 && sum > {1'b0, threshold_q}) begin
          result_d = {5'b0, best_idx, 8'b0};
        end
      end
      lvp_pkg::ModeExtreme: begin
        result_d = (lvp_pkg::abs_mag(zneg) > {1'b0, zpos}) ? zneg : zpos;
      end
      default: result_d = '0;
    endcase
  end

endmodule

// File: src/lvp_checker.sv
// Port-level checker for the laminar voxel probe, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lvp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_index_i,
  input logic [16:0] cfg_wdata_i
);

  // A stalled result holds.
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // An empty result stage never blocks requests.
  `ASSERT_IMPL(a_empty_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "request blocked with empty output")

  // Backpressure only comes from a stalled sink.
  `ASSERT_IMPL(a_full_stall, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "request blocked without stalled output")

  // Request taken under a stall fills both stages.
  `ASSERT_NEXT(a_fill, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready, m_axis_tvalid && (s_axis_tready == m_axis_tready), "both stages not full after stalled request")

endmodule

bind laminar_voxel_probe lvp_checker u_lvp_checker (.*);
